/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ray generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/crg_pkg.sv */
// ----------------------------------------------------------------------------
// Camera ray generator package
// Shared constants and register codes for the ray generator.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIM_BITS_DEF  = 12;
  localparam int OUT_BITS      = 18;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  // Normalized magnitudes have their leading one at bit NORM_W-1.
  localparam int NORM_W        = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X  = 3'd0,
    REG_CAM_Y  = 3'd1,
    REG_CAM_Z  = 3'd2,
    REG_LOOK_X = 3'd3,
    REG_LOOK_Y = 3'd4,
    REG_LOOK_Z = 3'd5,
    REG_HEIGHT = 3'd6,
    REG_WIDTH  = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] CAM_X_RST  = 32'h0000_0000;
  localparam logic [CFG_W-1:0] CAM_Y_RST  = 32'h0005_0000;
  localparam logic [CFG_W-1:0] CAM_Z_RST  = 32'hFFF6_0000;
  localparam logic [CFG_W-1:0] LOOK_X_RST = 32'h0000_0000;
  localparam logic [CFG_W-1:0] LOOK_Y_RST = 32'h0000_0000;
  localparam logic [CFG_W-1:0] LOOK_Z_RST = 32'h0000_0000;
  localparam int HEIGHT_RST = 360;
  localparam int WIDTH_RST  = 640;

endpackage

/* hw/rtl/crg_unit.sv */
// ----------------------------------------------------------------------------
// Vector normalization pipeline
// Scales a signed 3-vector to unit length with round-to-nearest division.
// ----------------------------------------------------------------------------
module crg_unit import crg_pkg::*; #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [2:0][IN_W-1:0]            in_vec,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic                            out_zero,
  output logic [2:0]                      out_neg,
  output logic [2:0][FRAC_BITS:0]         out_mag,
  output logic [SIDE_W-1:0]               out_side
);

  localparam int MSB_W  = $clog2(IN_W);
  localparam int SQ_W   = 2 * NORM_W + 2;
  localparam int SQ_IT  = NORM_W + 1;
  localparam int SQ_ST  = (SQ_IT + 1) / 2;
  localparam int LEN_W  = NORM_W + 1;
  localparam int REM_W  = LEN_W + 1;
  localparam int DIV_N  = FRAC_BITS + 1;
  localparam int DIV_ST = (DIV_N + 1) / 2;
  localparam int NUM_W  = NORM_W + FRAC_BITS + 1;

  logic [2:0][IN_W-1:0] mag_c;
  logic [IN_W-1:0]      top_c;
  logic                 s1_valid;
  logic [2:0]           s1_neg;
  logic [2:0][IN_W-1:0] s1_mag;
  logic [IN_W-1:0]      s1_top;
  logic [SIDE_W-1:0]    s1_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
    top_c = mag_c[0];
    if (mag_c[1] > top_c) top_c = mag_c[1];
    if (mag_c[2] > top_c) top_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s1_neg[i] <= in_vec[i][IN_W-1];
      s1_mag  <= mag_c;
      s1_top  <= top_c;
      s1_side <= in_side;
    end
  end

  logic [MSB_W-1:0]     msb_c;
  logic                 s2_valid;
  logic [2:0]           s2_neg;
  logic [2:0][IN_W-1:0] s2_mag;
  logic [MSB_W-1:0]     s2_msb;
  logic                 s2_zero;
  logic [SIDE_W-1:0]    s2_side;

  always_comb begin
    msb_c = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (s1_top[b]) msb_c = MSB_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg  <= s1_neg;
      s2_mag  <= s1_mag;
      s2_msb  <= msb_c;
      s2_zero <= (s1_top == '0);
      s2_side <= s1_side;
    end
  end

  logic [2:0][IN_W+NORM_W-2:0] wide_c;
  logic                        s3_valid;
  logic [2:0]                  s3_neg;
  logic [2:0][NORM_W-1:0]      s3_norm;
  logic                        s3_zero;
  logic [SIDE_W-1:0]           s3_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide_c[i] = {s2_mag[i], {(NORM_W-1){1'b0}}} >> s2_msb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s3_norm[i] <= wide_c[i][NORM_W-1:0];
      s3_neg  <= s2_neg;
      s3_zero <= s2_zero;
      s3_side <= s2_side;
    end
  end

  logic                     s4_valid;
  logic [2:0]               s4_neg;
  logic [2:0][NORM_W-1:0]   s4_norm;
  logic [2:0][2*NORM_W-1:0] s4_sq;
  logic                     s4_zero;
  logic [SIDE_W-1:0]        s4_side;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en) s4_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s4_sq[i] <= s3_norm[i] * s3_norm[i];
      s4_norm <= s3_norm;
      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
      s4_side <= s3_side;
    end
  end

  logic [SQ_W-1:0]              q_n    [SQ_ST+1];
  logic [SQ_W-1:0]              q_r    [SQ_ST+1];
  logic [2:0][NORM_W-1:0]       q_norm [SQ_ST+1];
  logic [2:0]                   q_neg  [SQ_ST+1];
  logic                         q_zero [SQ_ST+1];
  logic [SIDE_W-1:0]            q_side [SQ_ST+1];
  logic                         q_v    [SQ_ST+1];

  always_ff @(posedge clk) begin
    if (rst) q_v[0] <= 1'b0;
    else if (en) q_v[0] <= s4_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_n[0]    <= SQ_W'(s4_sq[0]) + SQ_W'(s4_sq[1]) + SQ_W'(s4_sq[2]);
      q_r[0]    <= '0;
      q_norm[0] <= s4_norm;
      q_neg[0]  <= s4_neg;
      q_zero[0] <= s4_zero;
      q_side[0] <= s4_side;
    end
  end

  for (genvar s = 0; s < SQ_ST; s++) begin : g_sqrt
    logic [SQ_W-1:0] n_c;
    logic [SQ_W-1:0] r_c;

    always_comb begin : step
      logic [SQ_W-1:0] b;
      logic [SQ_W-1:0] t;
      n_c = q_n[s];
      r_c = q_r[s];
      for (int k = 0; k < 2; k++) begin
        if (s * 2 + k < SQ_IT) begin
          b = SQ_W'(1) << (SQ_W - 2 - 2 * (s * 2 + k));
          t = r_c + b;
          if (n_c >= t) begin
            n_c = n_c - t;
            r_c = (r_c >> 1) + b;
          end else begin
            r_c = r_c >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) q_v[s+1] <= 1'b0;
      else if (en) q_v[s+1] <= q_v[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_n[s+1]    <= n_c;
        q_r[s+1]    <= r_c;
        q_norm[s+1] <= q_norm[s];
        q_neg[s+1]  <= q_neg[s];
        q_zero[s+1] <= q_zero[s];
        q_side[s+1] <= q_side[s];
      end
    end
  end

  logic [REM_W-1:0]             d_rem  [DIV_ST+1][3];
  logic [FRAC_BITS:0]           d_low  [DIV_ST+1][3];
  logic [LEN_W-1:0]             d_len  [DIV_ST+1];
  logic [2:0]                   d_neg  [DIV_ST+1];
  logic                         d_zero [DIV_ST+1];
  logic [SIDE_W-1:0]            d_side [DIV_ST+1];
  logic                         d_v    [DIV_ST+1];
  logic [LEN_W-1:0]             len_c;
  logic [2:0][NUM_W-1:0]        num_c;

  always_comb begin
    len_c = q_r[SQ_ST][LEN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      num_c[i] = {1'b0, q_norm[SQ_ST][i], {FRAC_BITS{1'b0}}} + NUM_W'(len_c >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) d_v[0] <= 1'b0;
    else if (en) d_v[0] <= q_v[SQ_ST];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_rem[0][i] <= REM_W'(num_c[i] >> (FRAC_BITS + 1));
        d_low[0][i] <= num_c[i][FRAC_BITS:0];
      end
      d_len[0]  <= len_c;
      d_neg[0]  <= q_neg[SQ_ST];
      d_zero[0] <= q_zero[SQ_ST];
      d_side[0] <= q_side[SQ_ST];
    end
  end

  for (genvar s = 0; s < DIV_ST; s++) begin : g_div
    logic [REM_W-1:0]   rem_c [3];
    logic [FRAC_BITS:0] low_c [3];

    always_comb begin : step
      logic [REM_W-1:0] t;
      for (int i = 0; i < 3; i++) begin
        rem_c[i] = d_rem[s][i];
        low_c[i] = d_low[s][i];
        for (int k = 0; k < 2; k++) begin
          if (s * 2 + k < DIV_N) begin
            t        = {rem_c[i][REM_W-2:0], low_c[i][FRAC_BITS]};
            low_c[i] = {low_c[i][FRAC_BITS-1:0], 1'b0};
            if (t >= REM_W'(d_len[s])) begin
              t           = t - REM_W'(d_len[s]);
              low_c[i][0] = 1'b1;
            end
            rem_c[i] = t;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) d_v[s+1] <= 1'b0;
      else if (en) d_v[s+1] <= d_v[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          d_rem[s+1][i] <= rem_c[i];
          d_low[s+1][i] <= low_c[i];
        end
        d_len[s+1]  <= d_len[s];
        d_neg[s+1]  <= d_neg[s];
        d_zero[s+1] <= d_zero[s];
        d_side[s+1] <= d_side[s];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) out_mag[i] = d_low[DIV_ST][i];
  end

  assign out_valid = d_v[DIV_ST];
  assign out_zero  = d_zero[DIV_ST];
  assign out_neg   = d_neg[DIV_ST];
  assign out_side  = d_side[DIV_ST];

endmodule

/* hw/rtl/camera_ray_generator_top.sv */
// ----------------------------------------------------------------------------
// Camera ray generator
// Turns a pixel coordinate into the unit direction of its primary ray.
// ----------------------------------------------------------------------------
// At the default sizes the pipeline holds an input stage, two
// normalization pipelines of 31 stages each, three combination stages and
// the output register; square root and divider steps set the unit depth.
// Throughput is one word per cycle; a stall holds every stage in place.
// Synchronous reset empties the pipeline and loads the default camera.
module camera_ray_generator_top import crg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DIM_BITS  = DIM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [DIM_BITS-1:0]        pixel_x,
  input  logic [DIM_BITS-1:0]        pixel_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] dir_x,
  output logic signed [OUT_BITS-1:0] dir_y,
  output logic signed [OUT_BITS-1:0] dir_z,
  output logic                       degenerate
);

  `include "assert_macros.svh"

  localparam int K   = (2 * DIM_BITS + FRAC_BITS > 58) ? (2 * DIM_BITS + FRAC_BITS - 58) : 0;
  localparam int DW  = CFG_W + 1;
  localparam int FW  = FRAC_BITS + 2;
  localparam int AW  = 2 * DIM_BITS + 4;
  localparam int PW  = AW + FW;
  localparam int CW  = PW + 1;
  localparam int XW  = 2 * DIM_BITS;

  logic [CFG_W-1:0]    cam_x, cam_y, cam_z, look_x, look_y, look_z;
  logic [DIM_BITS:0]   img_h, img_w;
  logic                en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x  <= CAM_X_RST;
      cam_y  <= CAM_Y_RST;
      cam_z  <= CAM_Z_RST;
      look_x <= LOOK_X_RST;
      look_y <= LOOK_Y_RST;
      look_z <= LOOK_Z_RST;
      img_h  <= (DIM_BITS+1)'(HEIGHT_RST);
      img_w  <= (DIM_BITS+1)'(WIDTH_RST);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAM_X:  cam_x  <= cfg_data;
        REG_CAM_Y:  cam_y  <= cfg_data;
        REG_CAM_Z:  cam_z  <= cfg_data;
        REG_LOOK_X: look_x <= cfg_data;
        REG_LOOK_Y: look_y <= cfg_data;
        REG_LOOK_Z: look_z <= cfg_data;
        REG_HEIGHT: img_h  <= cfg_data[DIM_BITS:0];
        REG_WIDTH:  img_w  <= cfg_data[DIM_BITS:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                t0_valid;
  logic [2:0][DW-1:0]  t0_d;
  logic [XW-1:0]       t0_xy;

  always_ff @(posedge clk) begin
    if (rst) t0_valid <= 1'b0;
    else if (en) t0_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d[0] <= DW'($signed(look_x)) - DW'($signed(cam_x));
      t0_d[1] <= DW'($signed(look_y)) - DW'($signed(cam_y));
      t0_d[2] <= DW'($signed(look_z)) - DW'($signed(cam_z));
      t0_xy   <= {pixel_x, pixel_y};
    end
  end

  logic                     u1_valid, u1_zero;
  logic [2:0]               u1_neg;
  logic [2:0][FRAC_BITS:0]  u1_mag;
  logic [XW-1:0]            u1_xy;

  crg_unit #(.IN_W(DW), .FRAC_BITS(FRAC_BITS), .SIDE_W(XW)) u_fwd (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(t0_valid), .in_vec(t0_d), .in_side(t0_xy),
    .out_valid(u1_valid), .out_zero(u1_zero), .out_neg(u1_neg),
    .out_mag(u1_mag), .out_side(u1_xy)
  );

  logic [DIM_BITS:0]     wv, hv;
  logic signed [AW-1:0]  dx_c, dy_c, a_c, b_c, wh2_c;
  logic signed [FW-1:0]  f_c [3];

  always_comb begin
    wv = (img_w == '0) ? (DIM_BITS+1)'(1) : img_w;
    hv = (img_h == '0) ? (DIM_BITS+1)'(1) : img_h;
    dx_c  = $signed(AW'({u1_xy[XW-1:DIM_BITS], 1'b0})) - $signed(AW'(wv));
    dy_c  = $signed(AW'({u1_xy[DIM_BITS-1:0], 1'b0})) - $signed(AW'(hv));
    a_c   = dx_c * $signed(AW'(hv));
    b_c   = dy_c * $signed(AW'(wv));
    wh2_c = $signed((AW'(wv) * AW'(hv)) << 1);
    for (int i = 0; i < 3; i++) begin
      f_c[i] = $signed(FW'(u1_mag[i] >> K));
      if (u1_neg[i]) f_c[i] = -f_c[i];
    end
  end

  logic                 t1_valid, t1_deg;
  logic signed [FW-1:0] t1_f [3];
  logic signed [AW-1:0] t1_a, t1_b, t1_wh2;

  always_ff @(posedge clk) begin
    if (rst) t1_valid <= 1'b0;
    else if (en) t1_valid <= u1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_f   <= f_c;
      t1_a   <= a_c;
      t1_b   <= b_c;
      t1_wh2 <= wh2_c;
      t1_deg <= u1_zero;
    end
  end

  logic                 t2_valid, t2_deg;
  logic signed [PW-1:0] t2_p0, t2_p1, t2_p3, t2_p4, t2_p5, t2_bs;

  always_ff @(posedge clk) begin
    if (rst) t2_valid <= 1'b0;
    else if (en) t2_valid <= t1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_p0  <= PW'(t1_a) * PW'(t1_f[2]);
      t2_p1  <= PW'(t1_wh2) * PW'(t1_f[0]);
      t2_p3  <= PW'(t1_wh2) * PW'(t1_f[1]);
      t2_p4  <= PW'(t1_a) * PW'(t1_f[0]);
      t2_p5  <= PW'(t1_wh2) * PW'(t1_f[2]);
      t2_bs  <= PW'(t1_b) <<< (FRAC_BITS - K);
      t2_deg <= t1_deg;
    end
  end

  logic               t3_valid, t3_deg;
  logic [2:0][CW-1:0] t3_c;

  always_ff @(posedge clk) begin
    if (rst) t3_valid <= 1'b0;
    else if (en) t3_valid <= t2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_c[0] <= CW'(t2_p0) + CW'(t2_p1);
      t3_c[1] <= CW'(t2_p3) - CW'(t2_bs);
      t3_c[2] <= CW'(t2_p5) - CW'(t2_p4);
      t3_deg  <= t2_deg;
    end
  end

  logic                     u2_valid, u2_zero, u2_deg;
  logic [2:0]               u2_neg;
  logic [2:0][FRAC_BITS:0]  u2_mag;
  logic signed [FW-1:0]     r_c [3];

  crg_unit #(.IN_W(CW), .FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_dir (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(t3_valid), .in_vec(t3_c), .in_side(t3_deg),
    .out_valid(u2_valid), .out_zero(u2_zero), .out_neg(u2_neg),
    .out_mag(u2_mag), .out_side(u2_deg)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_c[i] = $signed(FW'(u2_mag[i]));
      if (u2_neg[i]) r_c[i] = -r_c[i];
      if (u2_zero || u2_deg) r_c[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= u2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_x      <= OUT_BITS'(r_c[0]);
      dir_y      <= OUT_BITS'(r_c[1]);
      dir_z      <= OUT_BITS'(r_c[2]);
      degenerate <= u2_zero || u2_deg;
    end
  end

  `ASSERT_CLK(a_deg_zero, clk, rst, out_valid && degenerate |-> dir_x == '0 && dir_y == '0 && dir_z == '0, "degenerate word carries a nonzero direction")
  `ASSERT_ALWAYS(a_rst_empty, clk, $past(rst) |-> !out_valid && !t0_valid && !u2_valid, "pipeline not empty after reset")
  `ASSERT_CLK(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(dir_x) && $stable(degenerate), "stalled result word changed")

endmodule
